/* hw/rtl/quadrature_decoder_speed_window_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the quadrature decoder speed window block
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef QUADRATURE_DECODER_SPEED_WINDOW_TOP_MACROS_SVH
`define QUADRATURE_DECODER_SPEED_WINDOW_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define QDSW_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define QDSW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/qdsw_pkg.sv */
// ----------------------------------------------------------------------------
// qdsw_pkg
// Shared constants, types and helpers for the quadrature speed window block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qdsw_pkg;

	// Width of the signed window step count
	localparam int COUNT_WIDTH = 16;
	// Width of the count times gain product (gain is 16 bit unsigned)
	localparam int PROD_WIDTH  = COUNT_WIDTH + 17;

	localparam int CFG_INDEX_WIDTH = 8;
	localparam int CFG_DATA_WIDTH  = 16;

	// Configuration register indexes
	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_WINDOW_TICKS = 8'd0,
		REG_SPEED_GAIN   = 8'd1
	} cfg_reg_t;

	localparam logic [15:0] WINDOW_TICKS_RESET = 16'd250;
	localparam logic [15:0] SPEED_GAIN_RESET   = 16'd161;
	localparam logic [15:0] TICK_LIMIT         = 16'hFFFF;

	localparam logic signed [COUNT_WIDTH-1:0] COUNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
	localparam logic signed [COUNT_WIDTH-1:0] COUNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

	// x4 quadrature step, indexed by {previous AB, current AB}
	localparam logic signed [1:0] STEP_TABLE [16] = '{
		2'sd0, -2'sd1, 2'sd1, 2'sd0, 2'sd1, 2'sd0, 2'sd0, -2'sd1,
		-2'sd1, 2'sd0, 2'sd0, 2'sd1, 2'sd0, 2'sd1, -2'sd1, 2'sd0
	};

	// Counter status towards the top level
	typedef struct packed {
		logic                          close;
		logic signed [COUNT_WIDTH-1:0] count;
	} win_status_t;

	// Clamp a product-width signed value to 16 bit signed
	function automatic logic signed [15:0] sat16(input logic signed [PROD_WIDTH-1:0] v);
		logic signed [PROD_WIDTH-1:0] hi;
		logic signed [PROD_WIDTH-1:0] lo;
		hi = PROD_WIDTH'(32767);
		lo = -PROD_WIDTH'(32768);
		if (v > hi) begin
			return 16'sh7FFF;
		end else if (v < lo) begin
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

endpackage

/* hw/rtl/qdsw_counter.sv */
// ----------------------------------------------------------------------------
// qdsw_counter
// Quadrature step decode, saturating window count and tick counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qdsw_counter
	import qdsw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,          // item moves through this cycle
	input  logic        mode,         // 1 = tick
	input  logic [1:0]  ab,           // A in bit 1, B in bit 0
	input  logic [15:0] window_ticks,
	output win_status_t status
);

	logic [1:0]                    prev_ab_q;
	logic signed [COUNT_WIDTH-1:0] step_count_q;
	logic [15:0]                   tick_count_q;

	logic signed [1:0]             step;
	logic signed [COUNT_WIDTH:0]   sum;
	logic signed [COUNT_WIDTH-1:0] count_next;
	logic [15:0]                   tick_next;
	logic                          close;

	// Step decode and saturating add
	always_comb begin
		step = STEP_TABLE[{prev_ab_q, ab}];
		sum  = {step_count_q[COUNT_WIDTH-1], step_count_q} + (COUNT_WIDTH+1)'(step);
		if (sum[COUNT_WIDTH] != sum[COUNT_WIDTH-1]) begin
			count_next = sum[COUNT_WIDTH] ? COUNT_MIN : COUNT_MAX;
		end else begin
			count_next = sum[COUNT_WIDTH-1:0];
		end
	end

	// Tick counter sticks at its limit
	assign tick_next = (tick_count_q < TICK_LIMIT) ? tick_count_q + 16'd1 : tick_count_q;
	assign close     = mode && (tick_next >= window_ticks);

	assign status.close = close;
	assign status.count = step_count_q;

	// State update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_ab_q    <= 2'b00;
			step_count_q <= '0;
			tick_count_q <= 16'd0;
		end else if (adv) begin
			if (!mode) begin
				prev_ab_q    <= ab;
				step_count_q <= count_next;
			end else if (close) begin
				step_count_q <= '0;
				tick_count_q <= 16'd0;
			end else begin
				tick_count_q <= tick_next;
			end
		end
	end

endmodule

/* hw/rtl/qdsw_speed.sv */
// ----------------------------------------------------------------------------
// qdsw_speed
// Window count clamp and Q8.8 speed: floor(count * gain / 256), saturated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qdsw_speed
	import qdsw_pkg::*;
(
	input  logic signed [COUNT_WIDTH-1:0] count,
	input  logic [15:0]                   gain,
	output logic signed [15:0]            window_count,
	output logic signed [15:0]            speed_rps_q8
);

	logic signed [PROD_WIDTH-1:0] count_ext;
	logic signed [PROD_WIDTH-1:0] prod;
	logic signed [PROD_WIDTH-1:0] scaled;

	// One signed multiply, arithmetic shift gives the floor
	always_comb begin
		count_ext    = PROD_WIDTH'(count);
		prod         = count_ext * $signed({{(PROD_WIDTH-16){1'b0}}, gain});
		scaled       = prod >>> 8;
		window_count = sat16(count_ext);
		speed_rps_q8 = sat16(scaled);
	end

endmodule

/* hw/rtl/quadrature_decoder_speed_window_top.sv */
// ----------------------------------------------------------------------------
// quadrature_decoder_speed_window_top
// x4 quadrature decoder with a windowed speed measurement in Q8.8 rps.
// ----------------------------------------------------------------------------
//  channel  | dir | content
//  s_*      | in  | encoder sample or millisecond tick (tuser = mode)
//  m_*      | out | window count and speed, one per closed window
//  cfg_*    | in  | register write: window ticks, speed gain
//
//  One item per cycle while no tick is held back by a stalled result; an item
//  waits in the input register, and a closing tick's result goes to the output register.
//  The state update and the single count x gain multiply sit in the same cycle.
//  arst_n clears state, configuration to reset values and all valid flags.
//  A stalled result holds back a tick in the input register and every item behind it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quadrature_decoder_speed_window_top
	import qdsw_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [7:0]                 s_tdata,   // [0] phase_a, [1] phase_b, rest zero
	input  logic                       s_tuser,   // [0] mode
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [31:0]                m_tdata,   // [15:0] window_count, [31:16] speed_rps_q8
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

	logic        in_valid_s1;
	logic        in_mode_s1;
	logic [1:0]  in_ab_s1;

	logic [15:0] window_ticks_q;
	logic [15:0] speed_gain_q;

	logic        out_valid_q;
	logic [31:0] out_data_q;

	logic               adv;
	win_status_t        status;
	logic signed [15:0] window_count;
	logic signed [15:0] speed_rps_q8;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_ticks_q <= WINDOW_TICKS_RESET;
			speed_gain_q   <= SPEED_GAIN_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_WINDOW_TICKS: window_ticks_q <= cfg_data;
				REG_SPEED_GAIN:   speed_gain_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Held item moves on unless it is a tick and the result slot is blocked
	assign adv      = in_valid_s1 && (!in_mode_s1 || !out_valid_q || m_tready);
	assign s_tready = !in_valid_s1 || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			in_mode_s1 <= s_tuser;
			in_ab_s1   <= {s_tdata[0], s_tdata[1]};
		end
	end

	qdsw_counter u_counter (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.mode         (in_mode_s1),
		.ab           (in_ab_s1),
		.window_ticks (window_ticks_q),
		.status       (status)
	);

	qdsw_speed u_speed (
		.count        (status.count),
		.gain         (speed_gain_q),
		.window_count (window_count),
		.speed_rps_q8 (speed_rps_q8)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && status.close) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && status.close) begin
			out_data_q <= {speed_rps_q8, window_count};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// Checks
	`include "quadrature_decoder_speed_window_top_macros.svh"

	`QDSW_ASSERT_SAME(a_no_overwrite, adv && status.close && out_valid_q, m_tready, "result overwritten before transfer")
	`QDSW_ASSERT_NEXT(a_close_gives_result, adv && status.close, m_tvalid, "closed window produced no result")
	`QDSW_ASSERT_SAME(a_empty_ready, !in_valid_s1, s_tready, "input register empty but not ready")

endmodule

/* tb/sv/qdsw_window_checker.sv */
// ----------------------------------------------------------------------------
// qdsw_window_checker
// Watches the sample, result and register channels of the quadrature speed
// window block, keeps its own copy of decoder state, predicts each closed
// window and compares every result transfer field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qdsw_window_checker
	import qdsw_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	input  logic                       s_tready,
	input  logic [7:0]                 s_tdata,   // [0] phase_a, [1] phase_b, rest zero
	input  logic                       s_tuser,   // [0] mode
	input  logic                       m_tvalid,
	input  logic                       m_tready,
	input  logic [31:0]                m_tdata,   // [15:0] window_count, [31:16] speed_rps_q8
	input  logic                       cfg_valid,
	input  logic                       cfg_ready,
	input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
	output int                         fail_count,
	output int                         pending
);

	localparam logic MODE_SAMPLE = 1'b0;
	localparam int   REPORT_MAX  = 10;

	typedef struct packed {
		logic signed [15:0] count;
		logic signed [15:0] speed;
	} window_result_t;

	window_result_t expected_windows [$];

	// Shadow copy of configuration and decoder state
	logic [15:0]                   window_ticks_q;
	logic [15:0]                   speed_gain_q;
	logic [1:0]                    prev_ab;
	logic signed [COUNT_WIDTH-1:0] step_count;
	logic [15:0]                   tick_count;

	// x4 decode of {previous AB, current AB}: forward is 00-10-11-01
	function automatic int quad_step(input logic [3:0] pair);
		case (pair)
			4'd2, 4'd4, 4'd11, 4'd13: return 1;
			4'd1, 4'd7, 4'd8, 4'd14:  return -1;
			default:                  return 0;
		endcase
	endfunction

	function automatic logic signed [15:0] clamp16(input longint v);
		if (v > 32767)
			return 16'sh7FFF;
		if (v < -32768)
			return 16'sh8000;
		return v[15:0];
	endfunction

	// Advance the shadow state by one accepted item
	task automatic decode_item(input logic mode, input logic a, input logic b);
		longint         sum;
		longint         product;
		window_result_t w;
		if (mode == MODE_SAMPLE) begin
			sum = longint'(step_count) + quad_step({prev_ab, a, b});
			if (sum > longint'(COUNT_MAX))
				sum = longint'(COUNT_MAX);
			else if (sum < longint'(COUNT_MIN))
				sum = longint'(COUNT_MIN);
			step_count = sum[COUNT_WIDTH-1:0];
			prev_ab    = {a, b};
		end else begin
			if (tick_count != TICK_LIMIT)
				tick_count = tick_count + 16'd1;
			if (tick_count >= window_ticks_q) begin
				product = longint'(step_count) * longint'(speed_gain_q);
				w.count = clamp16(longint'(step_count));
				// arithmetic shift floors towards minus infinity
				w.speed = clamp16(product >>> 8);
				expected_windows.push_back(w);
				step_count = '0;
				tick_count = '0;
			end
		end
	endtask

	task automatic note_failure(input string what, input window_result_t w, input logic [31:0] got);
		if (fail_count < REPORT_MAX)
			$display("%0t: %s: expected count %0d speed %0d, got count %0d speed %0d",
				$realtime, what, w.count, w.speed,
				$signed(got[15:0]), $signed(got[31:16]));
		fail_count = fail_count + 1;
	endtask

	// Sample all three channels at the rising edge
	always @(posedge clk or negedge arst_n) begin : monitor
		window_result_t w;
		if (!arst_n) begin
			window_ticks_q = WINDOW_TICKS_RESET;
			speed_gain_q   = SPEED_GAIN_RESET;
			prev_ab        = '0;
			step_count     = '0;
			tick_count     = '0;
			fail_count     = 0;
			expected_windows.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_WINDOW_TICKS: window_ticks_q = cfg_data;
					REG_SPEED_GAIN:   speed_gain_q   = cfg_data;
					default:          ;
				endcase
			end
			if (s_tvalid && s_tready)
				decode_item(s_tuser, s_tdata[0], s_tdata[1]);
			if (m_tvalid && m_tready) begin
				if (expected_windows.size() == 0) begin
					w = '0;
					note_failure("result with nothing outstanding", w, m_tdata);
				end else begin
					w = expected_windows.pop_front();
					if (m_tdata[15:0] !== w.count || m_tdata[31:16] !== w.speed)
						note_failure("window mismatch", w, m_tdata);
				end
			end
		end
		pending = expected_windows.size();
	end

endmodule

/* tb/sv/tb_quadrature_decoder_speed_window_top.sv */
// ----------------------------------------------------------------------------
// tb_quadrature_decoder_speed_window_top
// Drives encoder samples and millisecond ticks into the speed window block
// under random back-pressure, covering table entries, window and gain limits,
// speed saturation and a long output stall; the checker does the comparing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_quadrature_decoder_speed_window_top;
	import qdsw_pkg::*;

	localparam logic MODE_SAMPLE = 1'b0;
	localparam logic MODE_TICK   = 1'b1;
	// Index with no register behind it
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNMAPPED = 8'd2;

	localparam int LATENCY_PAD = 8;
	localparam int HOLD_CYCLES = 400;
	localparam int SAT_STEPS   = 150;
	localparam int PHASE_ITEMS = 240;
	localparam int CYCLE_LIMIT = 600000;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       s_tvalid = 1'b0;
	logic                       s_tready;
	logic [7:0]                 s_tdata = '0;
	logic                       s_tuser = 1'b0;
	logic                       m_tvalid;
	logic                       m_tready = 1'b0;
	logic [31:0]                m_tdata;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
	logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;

	int   fail_count;
	int   pending;
	int   cycle_count = 0;
	bit   no_idle = 1'b0;
	bit   long_hold_req = 1'b0;
	logic [1:0] last_ab = 2'b00;

	quadrature_decoder_speed_window_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	qdsw_window_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #10 clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("quadrature_decoder_speed_window_top test failed");
			$finish;
		end
	end

	// Next AB level along the gray sequence, forward or backward
	function automatic logic [1:0] next_ab(input logic [1:0] ab, input bit fwd);
		case (ab)
			2'b00:   return fwd ? 2'b10 : 2'b01;
			2'b10:   return fwd ? 2'b11 : 2'b00;
			2'b11:   return fwd ? 2'b01 : 2'b10;
			default: return fwd ? 2'b00 : 2'b11;
		endcase
	endfunction

	// One item on the sample channel; called and returns at a falling edge
	task automatic send_item(input logic mode, input logic [1:0] ab);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {6'd0, ab[0], ab[1]};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_sample(input logic [1:0] ab);
		last_ab = ab;
		send_item(MODE_SAMPLE, ab);
	endtask

	// Stop offering, wait for every window result, then let the pipe empty
	task automatic drain();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (LATENCY_PAD) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Mostly clean rotation with random direction changes, some glitches
	task automatic random_burst(input int n, input int tick_pct, input bit dir);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < tick_pct)
				send_item(MODE_TICK, 2'($urandom_range(0, 3)));
			else if (r < 88)
				send_sample(next_ab(last_ab, ($urandom_range(0, 3) != 0) ? dir : !dir));
			else
				send_sample(2'($urandom_range(0, 3)));
		end
	endtask

	// Result side: random stall per result, one long hold-off on request
	initial begin : receiver
		int stall;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			stall = no_idle ? 0 : $urandom_range(0, 19);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!(m_tvalid && m_tready))
				@(posedge clk);
		end
	end

	// Stimulus
	initial begin : stimulus
		// de Bruijn walk over AB levels: visits every {previous, current} pair
		logic [1:0] walk [17] = '{2'd0, 2'd0, 2'd1, 2'd0, 2'd2, 2'd0, 2'd3, 2'd1, 2'd1,
			2'd2, 2'd1, 2'd3, 2'd2, 2'd2, 2'd3, 2'd3, 2'd0};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: full table, gain at maximum, ticks carrying junk levels
		write_reg(REG_SPEED_GAIN, 16'hFFFF);
		write_reg(REG_WINDOW_TICKS, 16'd2);
		for (int i = 0; i < 8; i++)
			send_sample(walk[i]);
		send_item(MODE_TICK, 2'b11);
		for (int i = 8; i < 17; i++)
			send_sample(walk[i]);
		send_item(MODE_TICK, 2'b11);
		drain();

		// Zero window closes on every tick; gain zero; unmapped write ignored
		write_reg(REG_WINDOW_TICKS, 16'd0);
		write_reg(REG_SPEED_GAIN, 16'd0);
		write_reg(REG_UNMAPPED, 16'd1);
		send_sample(next_ab(last_ab, 1'b1));
		send_item(MODE_TICK, 2'b01);
		send_sample(next_ab(last_ab, 1'b0));
		send_sample(next_ab(last_ab, 1'b0));
		send_item(MODE_TICK, 2'b10);
		drain();

		// Widest window does not close within the burst; lowering it closes on the next tick
		write_reg(REG_WINDOW_TICKS, 16'hFFFF);
		write_reg(REG_SPEED_GAIN, SPEED_GAIN_RESET);
		random_burst(40, 30, 1'b1);
		drain();
		write_reg(REG_WINDOW_TICKS, 16'd3);
		send_sample(next_ab(last_ab, 1'b1));
		send_item(MODE_TICK, 2'b00);
		drain();

		// Speed saturation both ways at maximum gain
		no_idle = 1'b1;
		write_reg(REG_WINDOW_TICKS, 16'd1);
		write_reg(REG_SPEED_GAIN, 16'hFFFF);
		for (int i = 0; i < SAT_STEPS; i++)
			send_sample(next_ab(last_ab, 1'b1));
		send_item(MODE_TICK, 2'b00);
		drain();
		for (int i = 0; i < SAT_STEPS; i++)
			send_sample(next_ab(last_ab, 1'b0));
		send_item(MODE_TICK, 2'b00);
		drain();

		// Long output hold-off while ticks keep coming: input must back up
		write_reg(REG_SPEED_GAIN, 16'd300);
		long_hold_req = 1'b1;
		random_burst(80, 70, 1'b1);
		drain();
		no_idle = 1'b0;

		// Random phases with fresh settings, one of them without idling
		for (int p = 0; p < 5; p++) begin
			write_reg(REG_WINDOW_TICKS,
				16'((p == 3) ? $urandom_range(1, 40) : $urandom_range(1, 6)));
			write_reg(REG_SPEED_GAIN, 16'($urandom_range(0, 65535)));
			no_idle = (p == 2);
			random_burst(PHASE_ITEMS, 25, 1'($urandom_range(0, 1)));
			drain();
		end
		no_idle = 1'b0;

		if (fail_count == 0 && pending == 0)
			$display("quadrature_decoder_speed_window_top test passed");
		else
			$display("quadrature_decoder_speed_window_top test failed");
		$finish;
	end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/qdsw_pkg.sv
hw/rtl/qdsw_counter.sv
hw/rtl/qdsw_speed.sv
hw/rtl/quadrature_decoder_speed_window_top.sv
tb/sv/qdsw_window_checker.sv
tb/sv/tb_quadrature_decoder_speed_window_top.sv
